/* rtl/apx_pkg.sv */
// Shared types, constants and binary32 arithmetic helpers for the approximate
// log2 / exp2 / pow unit. Multiply, add and int-to-float round to nearest even.
// No dependencies.
package apx_pkg;

   typedef enum logic [1:0] {
      OP_LOG2 = 2'd0,
      OP_EXP2 = 2'd1,
      OP_POW  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // One pipeline slot: operation, operands and three working values.
   typedef struct packed {
      logic        vld;
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } apx_stage_type;

   localparam int LOG_STAGES = 9;
   localparam int EXP_STAGES = 10;

   localparam logic [31:0] FP_SIGN       = 32'h8000_0000;
   localparam logic [31:0] FP_QNAN       = 32'h7FC0_0000;
   localparam logic [31:0] FP_SCALE_DOWN = 32'h3400_0000; // 2^-23
   localparam logic [31:0] FP_SCALE_UP   = 32'h4B00_0000; // 2^23
   localparam logic [31:0] FP_BIAS       = 32'h42FE_0000; // 127.0
   localparam logic [31:0] FP_NEG_BIAS   = 32'hC2FE_0000; // -127.0
   localparam logic [31:0] FP_LOG_CORR   = 32'h3EB1_7679; // 0.346607
   localparam logic [31:0] FP_POW_CORR   = 32'h3EAD_EE78; // 0.33971
   localparam logic [31:0] FP_NEG_ONE    = 32'hBF80_0000;

   // Leading zero count of a left-aligned word; 64 when the word is zero.
   function automatic logic [6:0] lzc64(input logic [63:0] v);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            n = 7'(63 - i);
         end
      end
      return n;
   endfunction

   // Rounds a significand with its leading one at bit 47 and a biased
   // exponent, handling underflow to subnormals and overflow to infinity.
   function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                            input logic [47:0] sig);
      logic [47:0]        s;
      logic signed [11:0] sh;
      logic               stk;
      logic [7:0]         ef;
      logic [23:0]        m;
      logic               g;
      logic               st;
      logic               inc;
      logic [30:0]        mag;
      s   = sig;
      ef  = e[7:0];
      stk = 1'b0;
      sh  = 12'sd0;
      if (sig == 48'd0) begin
         return {sgn, 31'd0};
      end
      if (e >= 12'sd255) begin
         return {sgn, 8'hFF, 23'd0};
      end
      if (e <= 12'sd0) begin
         sh = 12'sd1 - e;
         if (sh >= 12'sd48) begin
            stk = |sig;
            s   = 48'd0;
         end else begin
            stk = |(sig & ((48'd1 << sh[5:0]) - 48'd1));
            s   = sig >> sh[5:0];
         end
         ef = 8'd0;
      end
      m   = s[47:24];
      g   = s[23];
      st  = (|s[22:0]) | stk;
      inc = g & (st | m[0]);
      mag = {ef, m[22:0]} + {30'd0, inc};
      return {sgn, mag};
   endfunction

   function automatic logic fp_is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
   endfunction

   function automatic logic fp_is_inf(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic               sgn;
      logic [7:0]         ea;
      logic [7:0]         eb;
      logic [23:0]        ma;
      logic [23:0]        mb;
      logic [47:0]        p;
      logic [6:0]         lz;
      logic signed [11:0] e;
      sgn = a[31] ^ b[31];
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return FP_QNAN;
      end
      if (fp_is_inf(a) || fp_is_inf(b)) begin
         if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
            return FP_QNAN;
         end
         return {sgn, 8'hFF, 23'd0};
      end
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      p  = ma * mb;
      lz = lzc64({p, 16'd0});
      e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({5'd0, lz});
      return fp_round(sgn, e, p << lz[5:0]);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]        l;
      logic [31:0]        s;
      logic [7:0]         el;
      logic [7:0]         es;
      logic [7:0]         d;
      logic [50:0]        xl;
      logic [50:0]        ys;
      logic [50:0]        yf;
      logic [50:0]        sum;
      logic [50:0]        sn;
      logic               stk;
      logic               sub;
      logic [6:0]         lz;
      logic signed [11:0] e;
      logic [47:0]        sig;
      if (fp_is_nan(a) || fp_is_nan(b)) begin
         return FP_QNAN;
      end
      if (fp_is_inf(a) && fp_is_inf(b)) begin
         return (a[31] != b[31]) ? FP_QNAN : a;
      end
      if (fp_is_inf(a)) begin
         return a;
      end
      if (fp_is_inf(b)) begin
         return b;
      end
      if (a[30:0] < b[30:0]) begin
         l = b;
         s = a;
      end else begin
         l = a;
         s = b;
      end
      el  = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
      es  = (s[30:23] == 8'd0) ? 8'd1 : s[30:23];
      d   = el - es;
      xl  = {1'b0, (l[30:23] != 8'd0), l[22:0], 26'd0};
      yf  = {1'b0, (s[30:23] != 8'd0), s[22:0], 26'd0};
      if (d >= 8'd51) begin
         stk = |yf;
         ys  = 51'd0;
      end else begin
         stk = |(yf & ((51'd1 << d[5:0]) - 51'd1));
         ys  = yf >> d[5:0];
      end
      ys[0] = ys[0] | stk;
      sub   = l[31] ^ s[31];
      sum   = sub ? (xl - ys) : (xl + ys);
      if (sum == 51'd0) begin
         return {(sub ? 1'b0 : l[31]), 31'd0};
      end
      lz  = lzc64({sum, 13'd0});
      sn  = sum << lz[5:0];
      e   = $signed({4'd0, el}) + 12'sd1 - $signed({5'd0, lz});
      sig = {sn[50:4], sn[3] | (|sn[2:0])};
      return fp_round(l[31], e, sig);
   endfunction

   // Signed 32-bit integer to float.
   function automatic logic [31:0] fp_from_int(input logic [31:0] i);
      logic [31:0] mag;
      logic [6:0]  lz;
      logic [31:0] nrm;
      if (i == 32'd0) begin
         return 32'd0;
      end
      mag = i[31] ? (32'd0 - i) : i;
      lz  = lzc64({mag, 32'd0});
      nrm = mag << lz[4:0];
      return fp_round(i[31], 12'sd158 - $signed({5'd0, lz}), {nrm, 16'd0});
   endfunction

   // Truncating conversion to int32 with saturation; NaN gives zero.
   function automatic logic [31:0] fp_to_int(input logic [31:0] f);
      logic [31:0] m;
      logic [31:0] mag;
      if (fp_is_nan(f)) begin
         return 32'd0;
      end
      if (f[30:23] >= 8'd158) begin
         return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (f[30:23] < 8'd127) begin
         return 32'd0;
      end
      m = {8'd0, 1'b1, f[22:0]};
      if (f[30:23] >= 8'd150) begin
         mag = m << 5'(f[30:23] - 8'd150);
      end else begin
         mag = m >> 5'(8'd150 - f[30:23]);
      end
      return f[31] ? (32'd0 - mag) : mag;
   endfunction

   function automatic logic [31:0] fp_floor(input logic [31:0] f);
      logic [4:0]  fb;
      logic [30:0] mask;
      logic [31:0] t;
      if ((f[30:23] == 8'hFF) || (f[30:0] == 31'd0) || (f[30:23] >= 8'd150)) begin
         return f;
      end
      if (f[30:23] < 8'd127) begin
         return f[31] ? FP_NEG_ONE : 32'd0;
      end
      fb   = 5'(8'd150 - f[30:23]);
      mask = (31'd1 << fb) - 31'd1;
      t    = {f[31], f[30:0] & ~mask};
      if (f[31] && ((f[30:0] & mask) != 31'd0)) begin
         t[30:0] = t[30:0] + (31'd1 << fb);
      end
      return t;
   endfunction

endpackage

/* rtl/apx_log2_pipe.sv */
// Log2 half of the unit: nine register stages, one float operation each.
// Depends on apx_pkg. Result lands in field x.
module apx_log2_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  apx_pkg::apx_stage_type in_s,
   output logic                   in_ready,
   output apx_pkg::apx_stage_type out_s,
   input  logic                   out_ready
);
   import apx_pkg::*;

   apx_stage_type s_ff [LOG_STAGES];
   apx_stage_type s_in [LOG_STAGES];
   logic          en   [LOG_STAGES];

   always_comb begin
      s_in[0]   = in_s;
      s_in[0].x = fp_from_int(in_s.a);
      s_in[1]   = s_ff[0];
      s_in[1].x = fp_mul(s_ff[0].x, FP_SCALE_DOWN);
      s_in[2]   = s_ff[1];
      s_in[2].x = fp_add(s_ff[1].x, FP_NEG_BIAS);
      s_in[3]   = s_ff[2];
      s_in[3].y = fp_floor(s_ff[2].x);
      s_in[4]   = s_ff[3];
      s_in[4].y = fp_add(s_ff[3].x, s_ff[3].y ^ FP_SIGN);
      s_in[5]   = s_ff[4];
      s_in[5].z = fp_mul(s_ff[4].y, s_ff[4].y);
      s_in[6]   = s_ff[5];
      s_in[6].y = fp_add(s_ff[5].y, s_ff[5].z ^ FP_SIGN);
      s_in[7]   = s_ff[6];
      s_in[7].y = fp_mul(s_ff[6].y, FP_LOG_CORR);
      s_in[8]   = s_ff[7];
      s_in[8].x = fp_add(s_ff[7].x, s_ff[7].y);
   end

   // A stage loads when it is empty or its contents move on.
   always_comb begin
      en[LOG_STAGES-1] = !s_ff[LOG_STAGES-1].vld || out_ready;
      for (int k = LOG_STAGES - 2; k >= 0; k--) begin
         en[k] = !s_ff[k].vld || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LOG_STAGES; k++) begin
         if (reset) begin
            s_ff[k].vld <= 1'b0;
         end else if (en[k]) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign in_ready = en[0];
   assign out_s    = s_ff[LOG_STAGES-1];

endmodule

/* rtl/apx_exp2_pipe.sv */
// Exponent product and exp2 half of the unit: ten register stages.
// Depends on apx_pkg. Final result bits land in field z.
module apx_exp2_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  apx_pkg::apx_stage_type in_s,
   output logic                   in_ready,
   output apx_pkg::apx_stage_type out_s,
   input  logic                   out_ready
);
   import apx_pkg::*;

   apx_stage_type s_ff [EXP_STAGES];
   apx_stage_type s_in [EXP_STAGES];
   logic          en   [EXP_STAGES];

   always_comb begin
      // Stage 0 picks the exp2 argument and parks the log2 result in a.
      s_in[0]   = in_s;
      s_in[0].a = in_s.x;
      case (in_s.op)
         OP_POW:  s_in[0].x = fp_mul(in_s.b, in_s.x);
         OP_EXP2: s_in[0].x = in_s.a;
         default: s_in[0].x = in_s.x;
      endcase
      s_in[1]   = s_ff[0];
      s_in[1].y = fp_floor(s_ff[0].x);
      s_in[2]   = s_ff[1];
      s_in[2].y = fp_add(s_ff[1].x, s_ff[1].y ^ FP_SIGN);
      s_in[3]   = s_ff[2];
      s_in[3].z = fp_mul(s_ff[2].y, s_ff[2].y);
      s_in[4]   = s_ff[3];
      s_in[4].y = fp_add(s_ff[3].y, s_ff[3].z ^ FP_SIGN);
      s_in[5]   = s_ff[4];
      s_in[5].y = fp_mul(s_ff[4].y, FP_POW_CORR);
      s_in[6]   = s_ff[5];
      s_in[6].z = fp_add(s_ff[5].x, FP_BIAS);
      s_in[7]   = s_ff[6];
      s_in[7].z = fp_add(s_ff[6].z, s_ff[6].y ^ FP_SIGN);
      s_in[8]   = s_ff[7];
      s_in[8].z = fp_mul(s_ff[7].z, FP_SCALE_UP);
      s_in[9]   = s_ff[8];
      case (s_ff[8].op) inside
         OP_LOG2:          s_in[9].z = s_ff[8].a;
         OP_EXP2, OP_POW:  s_in[9].z = fp_to_int(s_ff[8].z);
         default:          s_in[9].z = 32'd0;
      endcase
   end

   always_comb begin
      en[EXP_STAGES-1] = !s_ff[EXP_STAGES-1].vld || out_ready;
      for (int k = EXP_STAGES - 2; k >= 0; k--) begin
         en[k] = !s_ff[k].vld || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < EXP_STAGES; k++) begin
         if (reset) begin
            s_ff[k].vld <= 1'b0;
         end else if (en[k]) begin
            s_ff[k] <= s_in[k];
         end
      end
   end

   assign in_ready = en[0];
   assign out_s    = s_ff[EXP_STAGES-1];

endmodule

/* rtl/approx_log2_exp2_pow_unit_top.sv */
// Pipeline: an accepted request passes 9 log2 stages, 10 exp2 stages and 1 output
// register before rsp_tvalid. Throughput: one request per cycle unless rsp_tready stalls.
// The rate is set by the stage pipeline, each stage holding one float operation.
// Reset (synchronous, active high) empties every stage and the output register.
// Top level of the approximate log2 / exp2 / pow unit.
// Depends on apx_pkg, apx_log2_pipe and apx_exp2_pipe.
module approx_log2_exp2_pow_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // [31:0] operand_a, [63:32] operand_b
   input  logic [1:0]  req_tuser,  // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [31:0] result_bits
);
   import apx_pkg::*;

   apx_stage_type req_s;
   apx_stage_type mid_s;
   apx_stage_type fin_s;
   logic          mid_ready;
   logic          fin_ready;
   logic          rsp_tvalid_ff;
   logic          rsp_tvalid_in;
   logic [31:0]   rsp_data_ff;
   logic [31:0]   rsp_data_in;

   // The request enters the log2 pipe with operand_a also seeding the
   // working value x; the other working values start cleared.
   always_comb begin
      req_s     = '0;
      req_s.vld = req_tvalid;
      req_s.op  = op_type'(req_tuser);
      req_s.a   = req_tdata[31:0];
      req_s.b   = req_tdata[63:32];
      req_s.x   = req_tdata[31:0];
   end

   apx_log2_pipe u_log2 (
      .clock     (clock),
      .reset     (reset),
      .in_s      (req_s),
      .in_ready  (req_tready),
      .out_s     (mid_s),
      .out_ready (mid_ready)
   );

   apx_exp2_pipe u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .in_s      (mid_s),
      .in_ready  (mid_ready),
      .out_s     (fin_s),
      .out_ready (fin_ready)
   );

   // The output register takes a new result whenever it is empty or its
   // current result is being taken, so the pipe keeps moving while
   // rsp_tready is high.
   assign fin_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      if (fin_ready) begin
         rsp_tvalid_in = fin_s.vld;
         rsp_data_in   = fin_s.z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* test/apx_result_checker.sv */
// Result checker for the approximate log2 / exp2 / pow unit: watches both
// stream channels, predicts each result with its own binary32 arithmetic.
// Depends on apx_pkg for the operation codes.
`timescale 1ns / 100ps

module apx_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import apx_pkg::*;

   localparam logic [31:0] K_LOG_CORR = 32'h3EB1_7679;
   localparam logic [31:0] K_EXP_CORR = 32'h3EAD_EE78;
   localparam logic [31:0] K_BIAS     = 32'h42FE_0000;
   localparam logic [31:0] K_DOWN     = 32'h3400_0000;
   localparam logic [31:0] K_UP       = 32'h4B00_0000;

   logic [31:0] expected_results[$];

   assign pending = expected_results.size();

   function automatic bit is_nan32(input logic [31:0] f);
      return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
   endfunction

   // Exact widening of a binary32 pattern to a double.
   function automatic real to_real(input logic [31:0] f);
      logic [10:0] de;
      if (f[30:0] == 31'd0) begin
         return $bitstoreal({f[31], 63'd0});
      end
      if (f[30:23] == 8'hFF) begin
         return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'd0});
      end
      if (f[30:23] == 8'd0) begin
         return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * (2.0 ** -149);
      end
      de = 11'(f[30:23]) + 11'd896;
      return $bitstoreal({f[31], de, f[22:0], 29'd0});
   endfunction

   // Round a double to binary32, nearest even, with subnormals and overflow.
   function automatic logic [31:0] to_single(input real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] mag;
      int          e;
      int          sh;
      bit          up;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) begin
         return (d[51:0] != 52'd0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
      end
      if (d[62:52] == 11'd0) begin
         return {d[63], 31'd0};
      end
      e = int'(d[62:52]) - 1023;
      if (e > 127) begin
         return {d[63], 8'hFF, 23'd0};
      end
      sig = {11'd0, 1'b1, d[51:0]};
      sh  = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh >= 55) begin
         return {d[63], 31'd0};
      end
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      up   = (rem > half) || ((rem == half) && kept[0]);
      if (e >= -126) begin
         mag = 32'((e + 127) << 23) + {9'd0, kept[22:0]} + 32'(up);
      end else begin
         mag = kept[31:0] + 32'(up);
      end
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      return to_single(to_real(a) * to_real(b));
   endfunction

   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
      return to_single(to_real(a) + to_real(b));
   endfunction

   function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
      return fadd(a, {~b[31], b[30:0]});
   endfunction

   function automatic logic [31:0] ffloor(input logic [31:0] f);
      real v;
      real t;
      if (is_nan32(f) || (f[30:0] == 31'd0) || (f[30:23] >= 8'd150)) begin
         return f;
      end
      v = to_real(f);
      t = real'($rtoi(v));
      if (t > v) begin
         t = t - 1.0;
      end
      return to_single(t);
   endfunction

   function automatic logic [31:0] to_int_sat(input logic [31:0] f);
      real v;
      if (is_nan32(f)) begin
         return 32'd0;
      end
      v = to_real(f);
      if (v >= 2147483648.0) begin
         return 32'h7FFF_FFFF;
      end
      if (v < -2147483648.0) begin
         return 32'h8000_0000;
      end
      return 32'($rtoi(v));
   endfunction

   // Shared quadratic correction (fraction - fraction^2) * k.
   function automatic logic [31:0] correction(input logic [31:0] v, input logic [31:0] k);
      logic [31:0] fr;
      fr = fsub(v, ffloor(v));
      return fmul(fsub(fr, fmul(fr, fr)), k);
   endfunction

   function automatic logic [31:0] log2_bits(input logic [31:0] bits);
      logic [31:0] x;
      x = to_single(real'($signed(bits)));
      x = fsub(fmul(x, K_DOWN), K_BIAS);
      return fadd(x, correction(x, K_LOG_CORR));
   endfunction

   function automatic logic [31:0] exp2_bits(input logic [31:0] n);
      logic [31:0] x;
      x = fsub(fadd(n, K_BIAS), correction(n, K_EXP_CORR));
      return to_int_sat(fmul(x, K_UP));
   endfunction

   function automatic logic [31:0] predict_result(input op_type op, input logic [31:0] a,
                                                  input logic [31:0] b);
      case (op)
         OP_LOG2: return log2_bits(a);
         OP_EXP2: return exp2_bits(a);
         OP_POW:  return exp2_bits(fmul(b, log2_bits(a)));
         default: return 32'd0;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_result(op_type'(req_tuser), req_tdata[31:0],
                                                      req_tdata[63:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result_bits: unexpected response 0x%08h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else if (expected_results[0] !== rsp_tdata) begin
               $error("result_bits: expected 0x%08h, actual 0x%08h",
                      expected_results[0], rsp_tdata);
               fail_count <= fail_count + 1;
               void'(expected_results.pop_front());
            end else begin
               void'(expected_results.pop_front());
            end
         end
      end
   end

endmodule

/* test/tb_approx_log2_exp2_pow_unit_top.sv */
// Testbench top for approx_log2_exp2_pow_unit_top: drives directed and random
// requests with random idling, and reports the verdict from apx_result_checker.
// Depends on apx_pkg, the unit and the checker.
`timescale 1ns / 100ps

module tb_approx_log2_exp2_pow_unit_top;
   import apx_pkg::*;

   localparam int RANDOM_REQUESTS = 1600;
   localparam int QUIET_FROM      = 1350;
   localparam int DRAIN_CYCLES    = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   int          fail_count;
   int          pending;
   bit          quiet;
   int          stall_left;

   approx_log2_exp2_pow_unit_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   apx_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Free-running 4 ns clock.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // The response side stalls in random bursts until the quiet tail of the run, where no
   // new burst starts and it accepts every response.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (!quiet && ($urandom_range(0, 7) == 0)) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Present one request at a falling edge and hold it until it is accepted.
   // Afterward the sender may go idle for a random burst; when it does not,
   // valid simply stays high for the next request.
   task automatic send_request(input op_type op, input logic [31:0] a, input logic [31:0] b);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (!quiet && ($urandom_range(0, 5) == 0)) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // A float with a random sign and mantissa and an exponent in [lo, hi].
   function automatic logic [31:0] float_in(input int lo, input int hi);
      return {1'($urandom), 8'($urandom_range(lo, hi)), 23'($urandom)};
   endfunction

   initial begin
      int     pick;
      op_type op;
      logic [31:0] a;
      logic [31:0] b;
      quiet      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_NONE;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed part: the log2 argument is read as a signed integer, so its
      // extremes are zero, the most negative and the most positive patterns.
      send_request(OP_LOG2, 32'h0000_0000, 32'h0);
      send_request(OP_LOG2, 32'h8000_0000, 32'h0);
      send_request(OP_LOG2, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_LOG2, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_LOG2, 32'h3F80_0000, 32'h0);
      // Exp2 of infinities and NaN gives a NaN fraction and hence zero; a very large
      // argument saturates the integer conversion.
      send_request(OP_EXP2, 32'h7F80_0000, 32'h0);
      send_request(OP_EXP2, 32'hFF80_0000, 32'h0);
      send_request(OP_EXP2, 32'h7FC0_0000, 32'h0);
      send_request(OP_EXP2, 32'h4300_0000, 32'h0);
      send_request(OP_EXP2, 32'hC348_0000, 32'h0);
      send_request(OP_EXP2, 32'h8000_0000, 32'h0);
      send_request(OP_EXP2, 32'h0000_0001, 32'h0);
      send_request(OP_EXP2, 32'hBF00_0000, 32'h0);
      send_request(OP_EXP2, 32'h4B00_0001, 32'h0);
      // Pow with zero, infinite and NaN exponents, including infinity times zero.
      send_request(OP_POW, 32'h4080_0000, 32'h3F00_0000);
      send_request(OP_POW, 32'h3F80_0000, 32'h7F80_0000);
      send_request(OP_POW, 32'h4000_0000, 32'hFF80_0000);
      send_request(OP_POW, 32'h4000_0000, 32'h7FC0_0000);
      send_request(OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_POW, 32'h0000_0000, 32'h0000_0000);
      // The unused selector always answers zero.
      send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Let the pipeline drain completely once before the random part.
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == QUIET_FROM) begin
            quiet = 1'b1;
         end
         pick = $urandom_range(0, 99);
         op   = (pick < 30) ? OP_LOG2 : (pick < 60) ? OP_EXP2 : (pick < 96) ? OP_POW : OP_NONE;
         // Mostly operands in the useful range, sometimes any bit pattern.
         if ($urandom_range(0, 4) == 0) begin
            a = $urandom;
            b = $urandom;
         end else begin
            a = (op == OP_EXP2) ? float_in(100, 134) : {1'b0, 8'($urandom_range(90, 165)),
                                                      23'($urandom)};
            b = float_in(110, 131);
         end
         send_request(op, a, b);
      end

      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS approx_log2_exp2_pow_unit_top");
      end else begin
         $display("FAIL approx_log2_exp2_pow_unit_top");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL approx_log2_exp2_pow_unit_top");
      $finish;
   end

endmodule
